// ===== rtl/pgm709_pkg.sv =====
// shared types and constants for the rec709 inverse gamma block
`timescale 1ns / 1ps
package pgm709_pkg;

  // default fraction width of the fixed-point output
  localparam int FRAC_BITS_DEF = 16;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_GRAY     = 2'd0;
  localparam logic [1:0] CFG_OUTPUT_MODE  = 2'd1;
  localparam logic [1:0] CFG_SAMPLE_LIMIT = 2'd2;

  // output mode codes
  localparam logic MODE_GRAY = 1'b0;
  localparam logic MODE_FRAC = 1'b1;

  // one assembled sample on its way to the back end
  typedef struct packed {
    logic [15:0] sample;
    logic        last;
  } smp_t;

endpackage

// ===== rtl/pgm_rec709_inverse_gamma_top.sv =====
// top level of the rec709 inverse gamma converter for grayscale raster bytes
//
//  channel   dir  handshake            payload
//  cfg       in   cfg_we               cfg_index, cfg_data
//  in        in   in_valid/in_ready    data_byte
//  out       out  out_valid/out_ready  linear_value, is_last
//
// one sample at a time in the arithmetic unit; bytes queue two samples deep
// linear segment: per sample a pop, a 32-step restoring divider and a scale
// curve segment: pop, divider, square, then the bitwise ninth-root search over 32 root bits
//   that runs eight products of one shared 32x32 multiplier per bit, then scale
// sample at or above the maximum: pop, then scale with no divide
// reset is synchronous; a stalled output holds and backs up into the queue
`timescale 1ns / 1ps
module pgm_rec709_inverse_gamma_top #(
  parameter int FRAC_BITS = pgm709_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] linear_value,
  output logic        is_last
);
  import pgm709_pkg::*;

  logic [15:0] max_gray;
  logic        output_mode;
  logic [23:0] sample_limit;
  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_avail;
  smp_t        q_in;
  smp_t        q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_gray     <= 16'd255;
      output_mode  <= MODE_GRAY;
      sample_limit <= 24'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_GRAY:     max_gray     <= cfg_data[15:0];
        CFG_OUTPUT_MODE:  output_mode  <= cfg_data[0];
        CFG_SAMPLE_LIMIT: sample_limit <= cfg_data;
        default:          ;
      endcase
    end
  end

  // byte intake
  pgm709_front u_front (
    .clk          (clk),
    .rst          (rst),
    .max_gray     (max_gray),
    .sample_limit (sample_limit),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  // sample queue
  pgm709_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .head      (q_head)
  );

  // arithmetic
  pgm709_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .max_gray     (max_gray),
    .output_mode  (output_mode),
    .q_avail      (q_avail),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .linear_value (linear_value),
    .is_last      (is_last)
  );

endmodule

// ===== rtl/pgm709_front.sv =====
// byte intake: pairs bytes into samples when wide, counts samples against the limit
`timescale 1ns / 1ps
module pgm709_front (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        max_gray,
  input  logic [23:0]        sample_limit,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               q_full,
  output logic               q_push,
  output pgm709_pkg::smp_t   q_data
);
  import pgm709_pkg::*;

  logic [7:0]  held_high_byte;
  logic        high_byte_pending;
  logic [23:0] samples_done;
  logic [23:0] samples_done_next;
  logic        accept;
  logic        wide;
  logic        at_limit;

  assign in_ready          = !q_full;
  assign accept            = in_valid && in_ready;
  assign wide              = (max_gray > 16'd255);
  assign at_limit          = (samples_done >= sample_limit);
  assign samples_done_next = samples_done + 24'd1;

  // a sample is complete on every byte in narrow mode, on the low byte otherwise
  assign q_push        = accept && !at_limit && (!wide || high_byte_pending);
  assign q_data.sample = wide ? {held_high_byte, data_byte} : {8'd0, data_byte};
  assign q_data.last   = (samples_done_next == sample_limit);

  // pairing and counting state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_high_byte    <= 8'd0;
      high_byte_pending <= 1'b0;
      samples_done      <= 24'd0;
    end else if (accept && !at_limit) begin
      if (wide) begin
        if (!high_byte_pending) begin
          held_high_byte <= data_byte;
        end
        high_byte_pending <= !high_byte_pending;
      end else begin
        high_byte_pending <= 1'b0;
      end
      if (q_push) begin
        samples_done <= samples_done_next;
      end
    end
  end

endmodule

// ===== rtl/pgm709_queue.sv =====
// two-entry sample queue between intake and arithmetic
`timescale 1ns / 1ps
module pgm709_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  pgm709_pkg::smp_t   push_data,
  output logic               full,
  input  logic               pop,
  output logic               avail,
  output pgm709_pkg::smp_t   head
);
  import pgm709_pkg::*;

  smp_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign head  = slot[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/pgm709_back.sv =====
// arithmetic: divide, then square and bitwise ninth root on the curve segment, scale, output register
`timescale 1ns / 1ps
module pgm709_back #(
  parameter int FRAC_BITS = pgm709_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        max_gray,
  input  logic               output_mode,
  input  logic               q_avail,
  input  pgm709_pkg::smp_t   q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [16:0]        linear_value,
  output logic               is_last
);
  import pgm709_pkg::*;

  localparam logic [49:0] RND_FRAC = 50'd1 << (31 - FRAC_BITS);
  localparam logic [49:0] RND_GRAY = 50'd1 << 31;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIV   = 7'b0000010,
    ST_SQR   = 7'b0000100,
    ST_INIT  = 7'b0001000,
    ST_POW   = 7'b0010000,
    ST_CMP   = 7'b0100000,
    ST_SCALE = 7'b1000000
  } st_t;

  st_t         state;
  logic        lin_seg;
  logic        last;
  logic [26:0] rem;
  logic [26:0] divisor;
  logic [31:0] quo;
  logic [4:0]  div_cnt;
  logic [31:0] t2;
  logic [31:0] root;
  logic [4:0]  bit_idx;
  logic [2:0]  mul_cnt;
  logic [31:0] pw;
  logic [32:0] lval;

  logic [15:0] m;
  logic [15:0] sat;
  logic        lin_now;
  logic [27:0] rem2;
  logic        sub_ok;
  logic [31:0] cand;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic        out_free;
  logic [49:0] gray_prod;
  logic [49:0] frac_sum;
  logic [16:0] result;
  logic [31:0] root_final;
  logic [63:0] curve_prod;

  // normalize the sample and pick the curve segment
  assign m       = (max_gray == 16'd0) ? 16'd1 : max_gray;
  assign sat     = (q_head.sample > m) ? m : q_head.sample;
  assign lin_now = (27'(sat) * 27'd1000) < (27'(m) * 27'd81);

  // restoring divide step
  assign rem2   = {rem, 1'b0};
  assign sub_ok = (rem2 >= {1'b0, divisor});

  // root candidate and the one shared multiplier
  assign cand = root | (32'd1 << bit_idx);
  always_comb begin
    case (state)
      ST_SQR:  begin mul_a = quo;  mul_b = quo;  end
      ST_POW:  begin mul_a = pw;   mul_b = cand; end
      default: begin mul_a = t2;   mul_b = root; end
    endcase
  end
  assign prod = 64'(mul_a) * 64'(mul_b);

  // curve result is t2 times the root, taken on the way out of the search
  assign root_final = (pw <= t2) ? cand : root;
  assign curve_prod = 64'(t2) * 64'(root_final);

  // final scaling
  assign gray_prod = 50'(lval) * 50'(m) + RND_GRAY;
  assign frac_sum  = 50'(lval) + RND_FRAC;
  assign result    = (output_mode == MODE_FRAC) ? frac_sum[32-FRAC_BITS +: 17]
                                                : gray_prod[48:32];

  assign out_free = !out_valid || out_ready;
  assign q_pop    = (state == ST_IDLE) && q_avail;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_avail) begin
            last    <= q_head.last;
            lin_seg <= lin_now;
            div_cnt <= 5'd31;
            quo     <= 32'd0;
            if (lin_now) begin
              rem     <= 27'({sat, 1'b0});
              divisor <= 27'(m) * 27'd9;
              state   <= ST_DIV;
            end else if (sat == m) begin
              lval  <= 33'h1_0000_0000;
              state <= ST_SCALE;
            end else begin
              rem     <= 27'(sat) * 27'd1000 + 27'(m) * 27'd99;
              divisor <= 27'(m) * 27'd1099;
              state   <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem     <= sub_ok ? 27'(rem2 - {1'b0, divisor}) : rem2[26:0];
          quo     <= {quo[30:0], sub_ok};
          div_cnt <= div_cnt - 5'd1;
          if (div_cnt == 5'd0) begin
            if (lin_seg) begin
              lval  <= {1'b0, quo[30:0], sub_ok};
              state <= ST_SCALE;
            end else begin
              state <= ST_SQR;
            end
          end
        end
        ST_SQR: begin
          t2      <= prod[63:32];
          root    <= 32'd0;
          bit_idx <= 5'd31;
          state   <= ST_INIT;
        end
        ST_INIT: begin
          pw      <= cand;
          mul_cnt <= 3'd0;
          state   <= ST_POW;
        end
        ST_POW: begin
          pw      <= prod[63:32];
          mul_cnt <= mul_cnt + 3'd1;
          if (mul_cnt == 3'd7) begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (pw <= t2) begin
            root <= cand;
          end
          if (bit_idx == 5'd0) begin
            lval    <= {1'b0, curve_prod[63:32]};
            state   <= ST_SCALE;
            lin_seg <= 1'b0;
          end else begin
            bit_idx <= bit_idx - 5'd1;
            state   <= ST_INIT;
          end
        end
        ST_SCALE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (state == ST_SCALE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCALE && out_free) begin
      linear_value <= result;
      is_last      <= last;
    end
  end

endmodule

// ===== rtl/pgm709_checker.sv =====
// port-level checks for the rec709 inverse gamma converter
`timescale 1ns / 1ps
module pgm709_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic [1:0]  cfg_index,
  input logic [23:0] cfg_data,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  data_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] linear_value,
  input logic        is_last
);

  // a stalled result beat holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(linear_value) && $stable(is_last))
    else $error("result beat changed while stalled");

  // after reset the intake is ready and the output register holds no result
  a_reset_clean: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("not empty after reset");

  // a result needs intake, queue and arithmetic, so none shows right after reset
  a_no_early_out: assert property (@(posedge clk)
    $past(rst) && $past(rst, 2) |-> !out_valid)
    else $error("result right after reset");

endmodule

bind pgm_rec709_inverse_gamma_top pgm709_checker u_checker (.*);
